@@ hw/rtl/lbt_pkg.sv @@
// Shared types and constants for the LED blink timer.
package lbt_pkg;

  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_SET     = 2'd1,
    MODE_CLEAR   = 2'd2,
    MODE_PATTERN = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // Timer entry of one LED.
  typedef struct packed {
    logic        lit;
    logic        blink;
    logic [31:0] off_dl;
    logic [31:0] on_dl;
    logic [23:0] period;
  } led_entry_t;

  // Command word held while the chain makes one full turn.
  typedef struct packed {
    mode_t       mode;
    logic [2:0]  led_index;
    logic        all_leds;
    logic [23:0] duration_ms;
    logic        blink_enable;
  } cmd_t;

  localparam int unsigned LevelW       = 8;
  localparam logic [15:0] StaggerReset = 16'd150;

endpackage

@@ hw/rtl/lbt_cell.sv @@
// One storage cell of the rotating LED entry chain.
module lbt_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               shift_en,
  input  lbt_pkg::led_entry_t entry_in,
  output lbt_pkg::led_entry_t entry_out
);
  import lbt_pkg::*;

  led_entry_t entry_r;
  led_entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (shift_en) begin
      entry_nxt = entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  assign entry_out = entry_r;

endmodule

@@ hw/rtl/lbt_update.sv @@
// Applies the current command to the LED entry leaving the head of the chain.
module lbt_update #(
  parameter int unsigned STEP_W = 3
) (
  input  lbt_pkg::cmd_t       cmd,
  input  logic [31:0]         now_ms,
  input  logic [31:0]         offset_ms,
  input  logic [STEP_W-1:0]   step,
  input  lbt_pkg::led_entry_t entry_in,
  output lbt_pkg::led_entry_t entry_out
);
  import lbt_pkg::*;

  logic        hit;
  logic [31:0] period_ext;
  logic [31:0] dur_ext;

  // The step is always below the LED count, so a match also bounds the index.
  assign hit        = (32'(cmd.led_index) == 32'(step));
  assign period_ext = 32'(entry_in.period);
  assign dur_ext    = 32'(cmd.duration_ms);

  always_comb begin
    entry_out = entry_in;
    case (cmd.mode)
      MODE_TICK: begin
        if (!entry_in.blink) begin
          if (now_ms > entry_in.off_dl) begin
            entry_out.lit = 1'b0;
          end
        end else if (entry_in.lit && (now_ms > entry_in.off_dl)) begin
          entry_out.lit   = 1'b0;
          entry_out.on_dl = now_ms + period_ext;
        end else if (!entry_in.lit && (now_ms > entry_in.on_dl)) begin
          entry_out.lit    = 1'b1;
          entry_out.off_dl = now_ms + period_ext;
        end
      end
      MODE_SET: begin
        if (cmd.all_leds || hit) begin
          entry_out.lit    = 1'b1;
          entry_out.off_dl = now_ms + dur_ext;
          entry_out.blink  = cmd.blink_enable;
          entry_out.period = cmd.blink_enable ? cmd.duration_ms : 24'd0;
        end
      end
      MODE_CLEAR: begin
        if (hit) begin
          entry_out.lit    = 1'b0;
          entry_out.off_dl = '0;
          entry_out.blink  = 1'b0;
        end
      end
      MODE_PATTERN: begin
        entry_out.lit    = 1'b0;
        entry_out.blink  = 1'b1;
        entry_out.period = cmd.duration_ms;
        entry_out.on_dl  = now_ms + offset_ms;
      end
      default: begin
        entry_out = entry_in;
      end
    endcase
  end

endmodule

@@ hw/rtl/led_timed_blink_controller.sv @@
// Top level of the multi-LED blink timer.
// A command word is taken only while the block is idle, and the block takes
// no new word until it is through with the last one. The LED entries sit in
// a ring of NUM_LEDS cells that rotates one place per cycle while a command
// runs, and a single update stage at the head of the ring applies the command
// to each entry as it passes, so every word makes one full turn of the ring.
// After the turn, the finishing state moves the pin levels into the output
// register and the block returns to idle to take the next word. While an
// earlier result word is stalled at the output, the block waits after its
// turn until that word leaves. Every command returns one result word with the
// current pin levels; these change only on a tick. The stagger register can
// only be written while the block is idle; cfg_ready is low otherwise.
module led_timed_blink_controller #(
  parameter int unsigned NUM_LEDS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [2:0]  in_led_index,
  input  logic        in_all_leds,
  input  logic [23:0] in_duration_ms,
  input  logic        in_blink_enable,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_led_levels,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_stagger_step_ms
);
  import lbt_pkg::*;

  localparam int unsigned StepW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam logic [StepW-1:0] LastStep = StepW'(NUM_LEDS - 1);

  state_t             state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [StepW-1:0]   step_r, step_nxt;
  logic [31:0]        now_r, now_nxt;
  logic [31:0]        offset_r, offset_nxt;
  logic [15:0]        stagger_r, stagger_nxt;
  logic [LevelW-1:0]  lv_r, lv_nxt;
  logic [LevelW-1:0]  pin_r, pin_nxt;
  logic [LevelW-1:0]  out_lv_r, out_lv_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               shift_en;
  logic               in_take;
  logic [31:0]        step_ext;

  led_entry_t         cell_q [NUM_LEDS];
  led_entry_t         head_upd;

  // Ring of cells: each cell takes its upper neighbor, the last takes the
  // updated head entry.
  for (genvar k = 0; k < NUM_LEDS; k++) begin : g_cell
    led_entry_t cell_d;
    if (k == NUM_LEDS - 1) begin : g_tail
      assign cell_d = head_upd;
    end else begin : g_mid
      assign cell_d = cell_q[k+1];
    end
    lbt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .entry_in (cell_d),
      .entry_out(cell_q[k])
    );
  end

  lbt_update #(
    .STEP_W(StepW)
  ) u_update (
    .cmd      (cmd_r),
    .now_ms   (now_r),
    .offset_ms(offset_r),
    .step     (step_r),
    .entry_in (cell_q[0]),
    .entry_out(head_upd)
  );

  assign in_take  = in_valid && !in_stall;
  assign step_ext = 32'(step_r);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    step_nxt      = step_r;
    now_nxt       = now_r;
    offset_nxt    = offset_r;
    stagger_nxt   = stagger_r;
    lv_nxt        = lv_r;
    pin_nxt       = pin_r;
    out_lv_nxt    = out_lv_r;
    out_valid_nxt = out_valid_r && out_stall;
    shift_en      = 1'b0;
    in_stall      = (state_r != ST_IDLE);

    if (cfg_valid && cfg_ready) begin
      stagger_nxt = cfg_stagger_step_ms;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt.mode         = mode_t'(in_mode);
          cmd_nxt.led_index    = in_led_index;
          cmd_nxt.all_leds     = in_all_leds;
          cmd_nxt.duration_ms  = in_duration_ms;
          cmd_nxt.blink_enable = in_blink_enable;
          step_nxt   = '0;
          offset_nxt = '0;
          lv_nxt     = '0;
          if (mode_t'(in_mode) == MODE_TICK) begin
            now_nxt = now_r + 32'd1;
          end
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        shift_en   = 1'b1;
        offset_nxt = offset_r + 32'(stagger_r);
        if (step_ext < 32'(LevelW)) begin
          lv_nxt[step_ext[2:0]] = head_upd.lit;
        end
        if (step_r == LastStep) begin
          step_nxt = '0;
          if (cmd_r.mode == MODE_TICK) begin
            pin_nxt = lv_nxt;
          end
          state_nxt = ST_DONE;
        end else begin
          step_nxt = step_r + StepW'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_lv_nxt    = pin_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      now_r       <= '0;
      stagger_r   <= StaggerReset;
      pin_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      now_r       <= now_nxt;
      stagger_r   <= stagger_nxt;
      pin_r       <= pin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    offset_r <= offset_nxt;
    lv_r     <= lv_nxt;
    out_lv_r <= out_lv_nxt;
  end

  // A stagger change in the middle of a pattern turn would split the offsets.
  assign cfg_ready      = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_led_levels = out_lv_r;

  // The ring must be back in index order whenever a new word can enter.
  a_ring_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (step_r == '0))
    else $error("LED ring not aligned while idle");

  // A result only appears once a full turn of the ring has finished.
  a_result_after_turn: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result word raised outside the finishing state");

  // The millisecond clock only moves after an accepted tick.
  a_clock_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(now_r)) |->
      $past(in_take && (mode_t'(in_mode) == MODE_TICK)))
    else $error("millisecond clock moved without a tick");

  // Pin levels change only at the end of a tick.
  a_pins_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(pin_r)) |-> $past(cmd_r.mode == MODE_TICK))
    else $error("pin levels changed outside a tick");

endmodule
